// ===== design/nixie_crossfade_pwm_driver_unit_defines.svh =====
// ----------------------------------------------------------------------------
// nixie crossfade pwm driver - assertion macros
// shared assertion wrappers for the block's checkers
// ----------------------------------------------------------------------------
`ifndef NIXIE_CROSSFADE_PWM_DRIVER_UNIT_DEFINES_SVH
`define NIXIE_CROSSFADE_PWM_DRIVER_UNIT_DEFINES_SVH

// assertion sampled on the rising edge, switched off while reset is low
`define NCFPWM_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("%m: assertion failed");

// assertion sampled on the rising edge, also live during reset
`define NCFPWM_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("%m: assertion failed");

`endif

// ===== design/ncfpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// ncfpwm_pkg
// types and constants shared by the nixie crossfade pwm driver
// ----------------------------------------------------------------------------
package ncfpwm_pkg;

  localparam int unsigned VAL_W     = 7;
  localparam int unsigned TIME_W    = 3 * VAL_W;
  localparam int unsigned CODE_W    = 4;
  localparam int unsigned LINES_W   = 6 * CODE_W + 2;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [CODE_W-1:0] BLANK_CODE    = 4'hF;
  localparam logic [CNT_W-1:0]  END_COMPARE   = 8'hFF;
  localparam logic [CNT_W-1:0]  BRIGHT_RELOAD = 8'hF0;
  localparam logic [CNT_W-1:0]  DUTY_RESET    = 8'd192;
  localparam logic [CNT_W-1:0]  STEP_RESET    = 8'd2;

  // all six tubes blank, both colons dark
  localparam logic [LINES_W-1:0] BLANK_LINES = {2'b00, {(6 * CODE_W){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_POINT         = 3'd0,
    REG_FADE_ENABLE        = 3'd1,
    REG_FADE_STEP          = 3'd2,
    REG_BLANK_LEADING_ZERO = 3'd3,
    REG_FULL_BRIGHT        = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0] duty_point;
    logic             fade_enable;
    logic [CNT_W-1:0] fade_step;
    logic             blank_leading_zero;
    logic             full_bright;
  } cfg_t;

endpackage

// ===== design/ncfpwm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ncfpwm_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module ncfpwm_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ncfpwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ncfpwm_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  output ncfpwm_pkg::cfg_t                    cfg_o
);
  import ncfpwm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DUTY_POINT:         cfg_nxt.duty_point         = cfg_wdata;
        REG_FADE_ENABLE:        cfg_nxt.fade_enable        = cfg_wdata[0];
        REG_FADE_STEP:          cfg_nxt.fade_step          = cfg_wdata;
        REG_BLANK_LEADING_ZERO: cfg_nxt.blank_leading_zero = cfg_wdata[0];
        REG_FULL_BRIGHT:        cfg_nxt.full_bright        = cfg_wdata[0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_point         <= DUTY_RESET;
      cfg_r.fade_enable        <= 1'b1;
      cfg_r.fade_step          <= STEP_RESET;
      cfg_r.blank_leading_zero <= 1'b0;
      cfg_r.full_bright        <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== design/ncfpwm_digit_enc.sv =====
// ----------------------------------------------------------------------------
// ncfpwm_digit_enc
// splits a packed time into six bcd driver codes plus colon lines
// ----------------------------------------------------------------------------
module ncfpwm_digit_enc (
  input  logic [ncfpwm_pkg::TIME_W-1:0]  time_val,
  input  logic [1:0]                     colons,
  input  logic                           blank_lz,
  output logic [ncfpwm_pkg::LINES_W-1:0] lines
);
  import ncfpwm_pkg::*;

  // divide by ten as multiply by 205 and shift by 11, exact below 128
  function automatic logic [CODE_W-1:0] div10(input logic [VAL_W-1:0] v);
    logic [VAL_W+7:0] prod;
    prod = (VAL_W + 8)'(v) * (VAL_W + 8)'(205);
    return prod[VAL_W+7:VAL_W+4];
  endfunction

  function automatic logic [CODE_W-1:0] ones_of(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] rem;
    rem = v - VAL_W'(div10(v)) * VAL_W'(10);
    return rem[CODE_W-1:0];
  endfunction

  function automatic logic [CODE_W-1:0] tens_code(input logic [VAL_W-1:0] v);
    logic [CODE_W-1:0] t;
    t = div10(v);
    return (t > CODE_W'(9)) ? BLANK_CODE : t;
  endfunction

  logic [VAL_W-1:0]  hrs, mins, secs;
  logic [CODE_W-1:0] hr_tens;

  assign hrs  = time_val[TIME_W-1:2*VAL_W];
  assign mins = time_val[2*VAL_W-1:VAL_W];
  assign secs = time_val[VAL_W-1:0];

  // leading zero suppression on the hour tens tube
  assign hr_tens = (blank_lz && (div10(hrs) == '0)) ? BLANK_CODE : tens_code(hrs);

  assign lines = {colons,
                  ones_of(secs), tens_code(secs),
                  ones_of(mins), tens_code(mins),
                  ones_of(hrs),  hr_tens};

endmodule

// ===== design/ncfpwm_frame_ctrl.sv =====
// ----------------------------------------------------------------------------
// ncfpwm_frame_ctrl
// frame counter, fade and brightness compares, drive line register
// ----------------------------------------------------------------------------
module ncfpwm_frame_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ncfpwm_pkg::cfg_t                    cfg,
  input  logic                                req_take,
  input  logic                                cmd,
  input  logic [ncfpwm_pkg::VAL_W-1:0]        hours,
  input  logic [ncfpwm_pkg::VAL_W-1:0]        minutes,
  input  logic [ncfpwm_pkg::VAL_W-1:0]        seconds,
  input  logic [1:0]                          colon_bits,
  input  logic                                start_fade,
  input  logic                                normal_mode,
  output logic [ncfpwm_pkg::LINES_W-1:0]      drive_lines
);
  import ncfpwm_pkg::*;

  logic [CNT_W-1:0]   frame_count_r, frame_count_nxt;
  logic [CNT_W-1:0]   fade_point_r, fade_point_nxt;
  logic [CNT_W-1:0]   bright_cmp_r, bright_cmp_nxt;
  logic [TIME_W-1:0]  new_time_r, new_time_nxt;
  logic [TIME_W-1:0]  old_time_r, old_time_nxt;
  logic [1:0]         colon_r, colon_nxt;
  logic [LINES_W-1:0] lines_r, lines_nxt;

  logic [CNT_W-1:0]   cnt_inc;
  logic               fade_hit, fade_dec, bright_hit;
  logic [TIME_W-1:0]  old_mid;
  logic               blank_lz;
  logic [LINES_W-1:0] new_lines, old_lines;

  assign cnt_inc    = frame_count_r + CNT_W'(1);
  assign fade_hit   = (cnt_inc == fade_point_r);
  assign fade_dec   = cfg.fade_enable && (fade_point_r > cfg.fade_step);
  assign bright_hit = (cnt_inc == bright_cmp_r);
  // fade end copies new time over old before the end of frame looks at it
  assign old_mid    = (fade_hit && !fade_dec) ? new_time_r : old_time_r;
  assign blank_lz   = cfg.blank_leading_zero && normal_mode;

  ncfpwm_digit_enc u_enc_new (
    .time_val (new_time_r),
    .colons   (colon_r),
    .blank_lz (blank_lz),
    .lines    (new_lines)
  );

  ncfpwm_digit_enc u_enc_old (
    .time_val (old_mid),
    .colons   (colon_r),
    .blank_lz (blank_lz),
    .lines    (old_lines)
  );

  always_comb begin
    frame_count_nxt = frame_count_r;
    fade_point_nxt  = fade_point_r;
    bright_cmp_nxt  = bright_cmp_r;
    new_time_nxt    = new_time_r;
    old_time_nxt    = old_time_r;
    colon_nxt       = colon_r;
    lines_nxt       = lines_r;
    if (req_take) begin
      if (cmd) begin
        new_time_nxt = {hours, minutes, seconds};
        colon_nxt    = colon_bits;
        if (start_fade) begin
          fade_point_nxt = cfg.duty_point;
        end
      end else begin
        frame_count_nxt = cnt_inc;
        old_time_nxt    = old_mid;
        if (fade_hit) begin
          lines_nxt = new_lines;
          if (fade_dec) begin
            fade_point_nxt = fade_point_r - cfg.fade_step;
          end
        end
        if (bright_hit) begin
          if (bright_cmp_r == cfg.duty_point) begin
            lines_nxt      = BLANK_LINES;
            bright_cmp_nxt = END_COMPARE;
          end else begin
            lines_nxt       = old_lines;
            bright_cmp_nxt  = cfg.full_bright ? BRIGHT_RELOAD : cfg.duty_point;
            frame_count_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      fade_point_r  <= DUTY_RESET;
      bright_cmp_r  <= DUTY_RESET;
      new_time_r    <= '0;
      old_time_r    <= '0;
      colon_r       <= '0;
      lines_r       <= '0;
    end else begin
      frame_count_r <= frame_count_nxt;
      fade_point_r  <= fade_point_nxt;
      bright_cmp_r  <= bright_cmp_nxt;
      new_time_r    <= new_time_nxt;
      old_time_r    <= old_time_nxt;
      colon_r       <= colon_nxt;
      lines_r       <= lines_nxt;
    end
  end

  assign drive_lines = lines_r;

endmodule

// ===== design/nixie_crossfade_pwm_driver_unit.sv =====
// latency: a request accepted at one edge shows its result from the next cycle on
// throughput: one request per cycle unless a result is stalled; the drive line
// register is the output stage, reloaded on fade or brightness hits of frame requests
// reset: synchronous active low; registers return to their power-on values,
// drive lines clear and no result is pending
// ----------------------------------------------------------------------------
// nixie_crossfade_pwm_driver_unit
// crossfading pwm driver for six bcd tubes and two colons
// ----------------------------------------------------------------------------
module nixie_crossfade_pwm_driver_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ncfpwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ncfpwm_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [ncfpwm_pkg::VAL_W-1:0]        in_hours,
  input  logic [ncfpwm_pkg::VAL_W-1:0]        in_minutes,
  input  logic [ncfpwm_pkg::VAL_W-1:0]        in_seconds,
  input  logic [1:0]                          in_colon_bits,
  input  logic                                in_start_fade,
  input  logic                                in_normal_mode,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ncfpwm_pkg::CODE_W-1:0]       out_hour_tens_code,
  output logic [ncfpwm_pkg::CODE_W-1:0]       out_hour_ones_code,
  output logic [ncfpwm_pkg::CODE_W-1:0]       out_minute_tens_code,
  output logic [ncfpwm_pkg::CODE_W-1:0]       out_minute_ones_code,
  output logic [ncfpwm_pkg::CODE_W-1:0]       out_second_tens_code,
  output logic [ncfpwm_pkg::CODE_W-1:0]       out_second_ones_code,
  output logic                                out_right_colon,
  output logic                                out_left_colon
);
  import ncfpwm_pkg::*;

  cfg_t               cfg;
  logic               req_take;
  logic               out_valid_r, out_valid_nxt;
  logic [LINES_W-1:0] lines;

  assign in_ready = !out_valid_r || out_ready;
  assign req_take = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (req_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  ncfpwm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  ncfpwm_frame_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .req_take    (req_take),
    .cmd         (in_cmd),
    .hours       (in_hours),
    .minutes     (in_minutes),
    .seconds     (in_seconds),
    .colon_bits  (in_colon_bits),
    .start_fade  (in_start_fade),
    .normal_mode (in_normal_mode),
    .drive_lines (lines)
  );

  assign out_valid            = out_valid_r;
  assign out_hour_tens_code   = lines[CODE_W-1:0];
  assign out_hour_ones_code   = lines[2*CODE_W-1:CODE_W];
  assign out_minute_tens_code = lines[3*CODE_W-1:2*CODE_W];
  assign out_minute_ones_code = lines[4*CODE_W-1:3*CODE_W];
  assign out_second_tens_code = lines[5*CODE_W-1:4*CODE_W];
  assign out_second_ones_code = lines[6*CODE_W-1:5*CODE_W];
  assign out_right_colon      = lines[6*CODE_W];
  assign out_left_colon       = lines[6*CODE_W+1];

endmodule

// ===== design/ncfpwm_checker.sv =====
// ----------------------------------------------------------------------------
// ncfpwm_checker
// port level checks for the nixie crossfade pwm driver
// ----------------------------------------------------------------------------
`include "nixie_crossfade_pwm_driver_unit_defines.svh"

module ncfpwm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ncfpwm_pkg::CODE_W-1:0] out_hour_tens_code,
  input logic [ncfpwm_pkg::CODE_W-1:0] out_hour_ones_code,
  input logic [ncfpwm_pkg::CODE_W-1:0] out_second_ones_code
);
  import ncfpwm_pkg::*;

  // nothing pending straight after reset
  `NCFPWM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // an empty output stage never stalls the input side
  `NCFPWM_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready)

  // every accepted request yields a result in the next cycle
  `NCFPWM_ASSERT(a_request_gives_result, clk, rst_n, (in_valid && in_ready) |=> out_valid)

  // a stalled result stays valid with its hour ones code stable
  `NCFPWM_ASSERT(a_result_holds, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hour_ones_code)))

  // the hour tens and second ones codes are a decimal digit or the blank code
  `NCFPWM_ASSERT(a_codes_legal, clk, rst_n,
    out_valid |-> ((out_hour_tens_code <= 4'd9 || out_hour_tens_code == BLANK_CODE) &&
                   (out_second_ones_code <= 4'd9 || out_second_ones_code == BLANK_CODE)))

endmodule

bind nixie_crossfade_pwm_driver_unit ncfpwm_checker u_ncfpwm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_hour_tens_code   (out_hour_tens_code),
  .out_hour_ones_code   (out_hour_ones_code),
  .out_second_ones_code (out_second_ones_code)
);
